// ----- src/checksummed_packet_framer_defines.svh -----
// assertion macros for the packet framer
`ifndef CHECKSUMMED_PACKET_FRAMER_DEFINES_SVH
`define CHECKSUMMED_PACKET_FRAMER_DEFINES_SVH

// checked only while out of reset
`define CPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// checked at every edge, reset included
`define CPF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- src/cpf_pkg.sv -----
package cpf_pkg;

    localparam int MAX_PAYLOAD = 26;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int HDR_LEN     = 5;
    localparam int HDR_W       = $clog2(HDR_LEN);

    localparam logic [7:0] HDR_K = 8'h4B;
    localparam logic [7:0] HDR_D = 8'h44;
    localparam logic [7:0] HDR_B = 8'h42;

    localparam logic [HDR_W-1:0] POS_K  = HDR_W'(0);
    localparam logic [HDR_W-1:0] POS_D  = HDR_W'(1);
    localparam logic [HDR_W-1:0] POS_B  = HDR_W'(2);
    localparam logic [HDR_W-1:0] POS_HI = HDR_W'(3);
    localparam logic [HDR_W-1:0] POS_LO = HDR_W'(4);

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } cpf_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } cpf_rd_t;

endpackage

// ----- src/checksummed_packet_framer.sv -----
// Packet framer: payload bytes are taken one per cycle into a buffer of
// MAX_PAYLOAD bytes with separate write and read ports while a running 8-bit
// sum is kept. When the buffer fills or a beat with s_last_byte arrives, the
// input stalls and the frame ('K', 'D', 'B', length high, length low,
// payload, checksum) streams out one byte per cycle while m_ready allows;
// each payload read is issued as the byte before it enters the output
// register, so the registered buffer read adds no gap. A full frame holds
// MAX_PAYLOAD + 6 bytes. The checksum beat carries m_frame_end, and
// m_message_done on the frame that closes the message. The buffer needs no
// clearing after reset.
module checksummed_packet_framer
    import cpf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_frame_end,
    output logic       m_message_done
);

`include "checksummed_packet_framer_defines.svh"

    typedef enum logic [3:0] {
        ST_FILL = 4'b0001,
        ST_HDR  = 4'b0010,
        ST_PAY  = 4'b0100,
        ST_SUM  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   fill_count_reg, fill_count_next;
    logic [7:0]         payload_sum_reg, payload_sum_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic               done_reg, done_next;
    logic [7:0]         csum_reg, csum_next;
    logic [HDR_W-1:0]   hdr_idx_reg, hdr_idx_next;
    logic [CNT_W-1:0]   pay_idx_reg, pay_idx_next;

    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_out_byte_reg, m_out_byte_next;
    logic               m_frame_end_reg, m_frame_end_next;
    logic               m_message_done_reg, m_message_done_next;

    cpf_wr_t            wr;
    cpf_rd_t            rd;
    logic [7:0]         rd_data;

    logic               in_beat;
    logic               out_free;
    logic [CNT_W-1:0]   fill_inc;
    logic [7:0]         sum_inc;
    logic [15:0]        len16;
    logic [CNT_W-1:0]   pay_inc;
    logic               hdr_not_started;

    cpf_payload_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == ST_FILL);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign fill_inc = fill_count_reg + CNT_W'(1);
    assign sum_inc  = payload_sum_reg + s_data_byte;
    assign len16    = 16'(len_reg);
    assign pay_inc  = pay_idx_reg + CNT_W'(1);

    // a held checksum beat may overlap buffering or the wait for the first header byte
    assign hdr_not_started = (state_reg == ST_FILL)
                             || (state_reg == ST_HDR && hdr_idx_reg == POS_K);

    assign wr.en   = in_beat;
    assign wr.addr = fill_count_reg[ADDR_W-1:0];
    assign wr.data = s_data_byte;

    always_comb begin
        state_next          = state_reg;
        fill_count_next     = fill_count_reg;
        payload_sum_next    = payload_sum_reg;
        len_next            = len_reg;
        done_next           = done_reg;
        csum_next           = csum_reg;
        hdr_idx_next        = hdr_idx_reg;
        pay_idx_next        = pay_idx_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_out_byte_next     = m_out_byte_reg;
        m_frame_end_next    = m_frame_end_reg;
        m_message_done_next = m_message_done_reg;
        rd.en               = 1'b0;
        rd.addr             = pay_idx_reg[ADDR_W-1:0];

        case (state_reg)
            ST_FILL: begin
                if (in_beat) begin
                    if (fill_inc == CNT_W'(MAX_PAYLOAD) || s_last_byte) begin
                        // close the frame: header bytes and sum are known now
                        state_next       = ST_HDR;
                        len_next         = fill_inc;
                        done_next        = s_last_byte;
                        csum_next        = sum_inc + HDR_K + HDR_D + HDR_B
                                           + 8'(fill_inc >> 8) + 8'(fill_inc);
                        hdr_idx_next     = POS_K;
                        pay_idx_next     = '0;
                        fill_count_next  = '0;
                        payload_sum_next = '0;
                    end else begin
                        fill_count_next  = fill_inc;
                        payload_sum_next = sum_inc;
                    end
                end
            end
            ST_HDR: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_frame_end_next    = 1'b0;
                    m_message_done_next = 1'b0;
                    case (hdr_idx_reg)
                        POS_K:   m_out_byte_next = HDR_K;
                        POS_D:   m_out_byte_next = HDR_D;
                        POS_B:   m_out_byte_next = HDR_B;
                        POS_HI:  m_out_byte_next = len16[15:8];
                        POS_LO:  m_out_byte_next = len16[7:0];
                        default: m_out_byte_next = HDR_K;
                    endcase
                    hdr_idx_next = hdr_idx_reg + HDR_W'(1);
                    if (hdr_idx_reg == POS_LO) begin
                        // prefetch the first payload byte
                        state_next = ST_PAY;
                        rd.en      = 1'b1;
                    end
                end
            end
            ST_PAY: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_out_byte_next     = rd_data;
                    m_frame_end_next    = 1'b0;
                    m_message_done_next = 1'b0;
                    pay_idx_next        = pay_inc;
                    if (pay_inc == len_reg) begin
                        state_next = ST_SUM;
                    end else begin
                        rd.en   = 1'b1;
                        rd.addr = pay_inc[ADDR_W-1:0];
                    end
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_out_byte_next     = csum_reg;
                    m_frame_end_next    = 1'b1;
                    m_message_done_next = done_reg;
                    state_next          = ST_FILL;
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_FILL;
            fill_count_reg  <= '0;
            payload_sum_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            fill_count_reg  <= fill_count_next;
            payload_sum_reg <= payload_sum_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg            <= len_next;
        done_reg           <= done_next;
        csum_reg           <= csum_next;
        hdr_idx_reg        <= hdr_idx_next;
        pay_idx_reg        <= pay_idx_next;
        m_out_byte_reg     <= m_out_byte_next;
        m_frame_end_reg    <= m_frame_end_next;
        m_message_done_reg <= m_message_done_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_out_byte_reg;
    assign m_frame_end    = m_frame_end_reg;
    assign m_message_done = m_message_done_reg;

    `CPF_ASSERT(a_fill_in_range, fill_count_reg < CNT_W'(MAX_PAYLOAD), "fill count overran buffer")
    `CPF_ASSERT(a_pay_idx_in_range, state_reg == ST_PAY |-> pay_idx_reg < len_reg, "read past length")
    `CPF_ASSERT(a_end_hold, (m_valid_reg && m_frame_end_reg) |-> hdr_not_started, "end beat overrun")
    `CPF_ASSERT(a_done_on_end, m_valid_reg && m_message_done_reg |-> m_frame_end_reg, "done off end")
    `CPF_ASSERT(a_no_fill_while_emit, state_reg != ST_FILL |=> fill_count_reg == '0, "fill in output")

endmodule

// ----- src/cpf_payload_ram.sv -----
module cpf_payload_ram
    import cpf_pkg::*;
(
    input  logic       aclk,
    input  cpf_wr_t    wr,
    input  cpf_rd_t    rd,
    output logic [7:0] rd_data
);

    logic [7:0] mem [MAX_PAYLOAD];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
